>>> rtl/core/horspool_substring_search_top_defines.svh
// Assertion macros for the checker file of the substring search block.
// Depends on nothing; include by bare file name.
`ifndef HORSPOOL_SUBSTRING_SEARCH_TOP_DEFINES_SVH
`define HORSPOOL_SUBSTRING_SEARCH_TOP_DEFINES_SVH

// Assert that an antecedent implies a consequent in the same cycle.
`define HSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle.
`define HSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/hss_pkg.sv
// Shared types and constants of the substring search block.
// No dependencies.
`timescale 1ns / 1ps
package hss_pkg;
  localparam int unsigned TextMax    = 4096;
  localparam int unsigned PatternMax = 64;
  localparam int unsigned TextAw     = $clog2(TextMax);
  localparam int unsigned PatAw      = $clog2(PatternMax);
  localparam int unsigned TlenW      = TextAw + 1;
  localparam int unsigned PlenW      = PatAw + 1;

  typedef enum logic [1:0] {
    OpAppendPat  = 2'd0,
    OpAppendText = 2'd1,
    OpSearch     = 2'd2,
    OpClear      = 2'd3
  } op_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_in;     // latch the accepted item, update stores
    logic tab_init;    // write skip table entry at sweep index
    logic tab_fill;    // write pattern-driven skip entry
    logic scan_start;  // i = start offset, j = m-1, sweep index cleared
    logic rd_last;     // last text char is on the read port: fetch its skip
    logic advance;     // i += skip, j = m-1
    logic cmp_next;    // j--, read ahead at j-1
    logic res_load;    // capture result
  } cmd_t;

  typedef struct packed {
    logic       trivial;    // empty pattern or pattern past text end
    logic       sweep_done; // table sweep index past the last entry
    logic       fill_done;  // pattern pass index at m-1
    logic       in_range;   // i <= n - m
    logic       last_eq;    // text char equals last pattern char
    logic       cmp_eq;     // compare bytes equal
    logic       cmp_done;   // j reached 0
  } sts_t;
endpackage

>>> rtl/core/horspool_substring_search_top.sv
// Top level of the Horspool substring search block.
// Depends on hss_pkg, hss_ctrl and hss_datapath.
`timescale 1ns / 1ps
// Usage:
//   Slave channel s_axis_* carries one item per transfer: tuser holds the
//   operation; tdata holds data_byte[7:0], start_offset[20:8].
//   Append items (pattern/text bytes) and clear are taken in the idle state
//   and may follow back to back.
//   A search item goes to a check state; an empty pattern or a pattern past
//   the text end goes straight to the result. Otherwise it runs a table sweep
//   over all 256 entries, a wait state and a pattern pass over the m pattern
//   bytes, a start state, then the scan: range check, last-byte read and skip
//   states per alignment plus a compare per further byte; the skip entry of
//   the last text byte sets the step. A miss costs one more range check.
//   The result register loads as the result state is left; intake reopens then.
//   Exactly one result per search leaves on m_axis_*: tdata holds
//   match_position[12:0]; tuser holds found.
//   Stores are block memories with registered reads; lengths reset to zero.
//   Reset clears the controller and lengths; store contents are undefined.
//   When the receiver stalls, hold the result in the output register; intake
//   goes on, and a later search waits with its result until the held one is
//   taken.
module horspool_substring_search_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // data_byte, start_offset
  input  logic [1:0]  s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // match_position
  output logic        m_axis_tuser    // found
);
  hss_pkg::cmd_t cmd;
  hss_pkg::sts_t sts;
  logic [12:0]   pos;

  hss_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .op_i(s_axis_tuser), .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready), .sts_i(sts), .cmd_o(cmd)
  );

  hss_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .op_i(s_axis_tuser),
    .byte_i(s_axis_tdata[7:0]), .start_i(s_axis_tdata[20:8]),
    .sts_o(sts), .pos_o(pos), .found_o(m_axis_tuser)
  );

  // pad match_position to a whole number of bytes
  assign m_axis_tdata = {3'b0, pos};
endmodule

>>> rtl/core/hss_datapath.sv
// Datapath: pattern/text memories, skip table, scan position and result.
// Depends on hss_pkg.
`timescale 1ns / 1ps
module hss_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  hss_pkg::cmd_t          cmd_i,
  input  logic [1:0]             op_i,
  input  logic [7:0]             byte_i,
  input  logic [12:0]            start_i,
  output hss_pkg::sts_t          sts_o,
  output logic [12:0]            pos_o,
  output logic                   found_o
);
  localparam int unsigned TW = hss_pkg::TlenW;
  localparam int unsigned PW = hss_pkg::PlenW;
  localparam int unsigned IW = TW + 1;

  logic [7:0] pat_mem [hss_pkg::PatternMax];
  logic [7:0] txt_mem [hss_pkg::TextMax];
  logic [PW-1:0] skip_mem [256];

  logic [PW-1:0] plen_q;
  logic [TW-1:0] tlen_q;
  logic [IW-1:0] i_q;
  logic [PW-1:0] j_q;
  logic [8:0]    k_q;
  logic [12:0]   start_q;
  logic [7:0]    t_rd_q, p_rd_q;
  logic [PW-1:0] skip_rd_q;
  logic [7:0]    pf_rd_q;
  logic [12:0]   pos_q;
  logic          found_q;

  logic [IW-1:0] lim, txt_addr;
  logic [PW-1:0] pat_addr, j_rd;
  logic [IW:0]   sm;
  logic          hit;
  logic          is_search;

  assign sm  = {{(IW+1-13){1'b0}}, start_q} + {{(IW+1-PW){1'b0}}, plen_q};
  assign lim = {{(IW-TW){1'b0}}, tlen_q} - {{(IW-PW){1'b0}}, plen_q};
  assign sts_o.trivial    = (plen_q == '0) || (sm > {{(IW+1-TW){1'b0}}, tlen_q});
  assign sts_o.sweep_done = k_q[8];
  assign sts_o.fill_done  = (k_q[PW-1:0] + PW'(1)) >= plen_q;
  assign sts_o.in_range   = i_q <= lim;
  assign sts_o.last_eq    = t_rd_q == p_rd_q;
  assign sts_o.cmp_eq     = t_rd_q == p_rd_q;
  assign sts_o.cmp_done   = j_q == '0;

  // read ahead at j-1 when stepping so compares run one byte a cycle
  assign j_rd     = cmd_i.cmp_next ? j_q - PW'(1) : j_q;
  assign txt_addr = i_q + {{(IW-PW){1'b0}}, j_rd};
  assign pat_addr = j_rd;

  assign hit       = (plen_q == '0) || (!sts_o.trivial && sts_o.in_range);
  assign is_search = cmd_i.load_in && (op_i == hss_pkg::OpSearch);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in && op_i == hss_pkg::OpAppendPat &&
        plen_q < PW'(hss_pkg::PatternMax))
      pat_mem[plen_q[PW-2:0]] <= byte_i;
    if (cmd_i.load_in && op_i == hss_pkg::OpAppendText &&
        tlen_q < TW'(hss_pkg::TextMax))
      txt_mem[tlen_q[TW-2:0]] <= byte_i;
    t_rd_q  <= txt_mem[txt_addr[TW-2:0]];
    p_rd_q  <= pat_mem[pat_addr[PW-2:0]];
    pf_rd_q <= pat_mem[k_q[PW-2:0]];
    if (cmd_i.rd_last) skip_rd_q <= skip_mem[t_rd_q];
    // pf_rd_q lags k by one, so the entry written at k belongs to byte k-1
    if (cmd_i.tab_init) skip_mem[k_q[7:0]] <= plen_q;
    else if (cmd_i.tab_fill) skip_mem[pf_rd_q] <= plen_q - k_q[PW-1:0];
    if (cmd_i.load_in) start_q <= start_i;
    if (cmd_i.res_load) begin
      pos_q   <= (plen_q == '0) ? start_q : (hit ? i_q[12:0] : tlen_q);
      found_q <= hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q <= '0; tlen_q <= '0; i_q <= '0; j_q <= '0; k_q <= '0;
    end else begin
      if (cmd_i.load_in) begin
        unique case (hss_pkg::op_e'(op_i))
          hss_pkg::OpAppendPat:
            if (plen_q < PW'(hss_pkg::PatternMax)) plen_q <= plen_q + PW'(1);
          hss_pkg::OpAppendText:
            if (tlen_q < TW'(hss_pkg::TextMax)) tlen_q <= tlen_q + TW'(1);
          hss_pkg::OpClear: begin plen_q <= '0; tlen_q <= '0; end
          default: ;
        endcase
      end
      if (is_search || cmd_i.scan_start) k_q <= '0;
      else if (cmd_i.tab_init || cmd_i.tab_fill) k_q <= k_q + 9'd1;
      if (cmd_i.scan_start) begin
        i_q <= IW'(start_q);
        j_q <= plen_q - PW'(1);
      end else if (cmd_i.advance) begin
        i_q <= i_q + {{(IW-PW){1'b0}}, skip_rd_q};
        j_q <= plen_q - PW'(1);
      end else if (cmd_i.cmp_next) begin
        j_q <= j_q - PW'(1);
      end
    end
  end

  assign pos_o   = pos_q;
  assign found_o = found_q;
endmodule

>>> rtl/core/hss_ctrl.sv
// Controller FSM sequencing load, table build, scan and result handoff.
// Depends on hss_pkg.
`timescale 1ns / 1ps
module hss_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    op_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  hss_pkg::sts_t sts_i,
  output hss_pkg::cmd_t cmd_o
);
  typedef enum logic [10:0] {
    SIdle  = 11'b00000000001, SChk  = 11'b00000000010, SInit = 11'b00000000100,
    SFill0 = 11'b00000001000, SFill = 11'b00000010000, SRng  = 11'b00000100000,
    SRdL   = 11'b00001000000, SWaitL= 11'b00010000000, SSkip = 11'b00100000000,
    SCmp   = 11'b01000000000, SRes  = 11'b10000000000
  } state_e;

  state_e st_q, st_d;
  logic   ov_q, ov_d;

  assign in_ready_o  = (st_q == SIdle);
  assign out_valid_o = ov_q;

  always_comb begin
    st_d = st_q; ov_d = ov_q; cmd_o = '0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (st_q)
      SIdle: if (in_valid_i) begin
        cmd_o.load_in = 1'b1;
        if (op_i == hss_pkg::OpSearch) st_d = SChk;
      end
      SChk: if (sts_i.trivial) st_d = SRes; else st_d = SInit;
      SInit: begin
        if (sts_i.sweep_done) begin cmd_o.scan_start = 1'b1; st_d = SFill0; end
        else cmd_o.tab_init = 1'b1;
      end
      SFill0: st_d = SFill;  // pattern read latency
      SFill: begin
        cmd_o.tab_fill = 1'b1;
        if (sts_i.fill_done) st_d = SRng;
      end
      SRng: begin
        cmd_o.scan_start = 1'b1; // i = start, j = m-1
        st_d = SRdL;
      end
      SRdL: if (!sts_i.in_range) st_d = SRes; else st_d = SWaitL;
      SWaitL: begin
        cmd_o.rd_last = 1'b1;
        if (!sts_i.last_eq) st_d = SSkip;
        else if (sts_i.cmp_done) st_d = SRes;
        else begin cmd_o.cmp_next = 1'b1; st_d = SCmp; end
      end
      SCmp: begin
        if (!sts_i.cmp_eq) st_d = SSkip;
        else if (sts_i.cmp_done) st_d = SRes;
        else cmd_o.cmp_next = 1'b1;
      end
      SSkip: begin cmd_o.advance = 1'b1; st_d = SRdL; end
      SRes: if (!ov_q || out_ready_i) begin
        cmd_o.res_load = 1'b1; ov_d = 1'b1; st_d = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin st_q <= SIdle; ov_q <= 1'b0; end
    else begin st_q <= st_d; ov_q <= ov_d; end
  end
endmodule

>>> rtl/core/hss_checker.sv
// Port-level checker for the substring search top, with its bind.
// Depends on horspool_substring_search_top_defines.svh and hss_pkg.
`timescale 1ns / 1ps
`include "horspool_substring_search_top_defines.svh"
module hss_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  `HSS_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result dropped")
  `HSS_ASSERT_IMP(a_pad, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[15:13] == 3'b0,
    "pad bits set")
  `HSS_ASSERT_NEXT(a_busy, clk_i, rst_ni,
    s_axis_tvalid && s_axis_tready && s_axis_tuser == hss_pkg::OpSearch,
    !s_axis_tready, "intake during search")
endmodule

bind horspool_substring_search_top hss_port_checker u_hss_port_checker (.*);
